// ===== sv/ner_pkg.sv =====
// Shared types and fixed field widths of the note event recorder and player.
package ner_pkg;

    localparam int NOTE_W  = 3;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [NOTE_W-1:0]  voice_notes;
        logic               recording_active;
        logic               playback_active;
        logic [COUNT_W-1:0] stored_events;
        logic               event_dropped;
    } t_result;

endpackage

// ===== sv/ner_if.sv =====
// Valid/ready channel interfaces for tick requests and result requests.
interface ner_in_if;
    logic                       valid;
    logic                       ready;
    logic [ner_pkg::NOTE_W-1:0] note_bits;
    logic                       record_button;
    logic                       play_button;

    modport source (output valid, note_bits, record_button, play_button, input ready);
    modport sink   (input valid, note_bits, record_button, play_button, output ready);
endinterface

interface ner_out_if;
    logic                        valid;
    logic                        ready;
    logic [ner_pkg::NOTE_W-1:0]  voice_notes;
    logic                        recording_active;
    logic                        playback_active;
    logic [ner_pkg::COUNT_W-1:0] stored_events;
    logic                        event_dropped;

    modport source (output valid, voice_notes, recording_active, playback_active,
                    stored_events, event_dropped, input ready);
    modport sink   (input valid, voice_notes, recording_active, playback_active,
                    stored_events, event_dropped, output ready);
endinterface

// ===== sv/ner_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module ner_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ner_skid.sv =====
// Two-entry output buffer that decouples result requests from tick acceptance.
module ner_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ner_pkg::t_result i_data,
    ner_out_if.source        o_out
);

    logic             r_out_vld;
    logic             r_skid_vld;
    ner_pkg::t_result r_out;
    ner_pkg::t_result r_skid;
    logic             w_take;
    logic             w_push;

    assign w_take  = r_out_vld && o_out.ready;
    assign w_push  = i_valid && !r_skid_vld;
    assign o_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_take) begin
                r_out     <= i_data;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= i_data;
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.voice_notes      = r_out.voice_notes;
    assign o_out.recording_active = r_out.recording_active;
    assign o_out.playback_active  = r_out.playback_active;
    assign o_out.stored_events    = r_out.stored_events;
    assign o_out.event_dropped    = r_out.event_dropped;

endmodule

// ===== sv/note_event_recorder_player.sv =====
// Top level of the note event recorder and player.
//
//  channel  dir  request carries
//  -------  ---  ---------------------------------------------------------------
//  i_in     in   one tick: note_bits, record_button, play_button
//  o_out    out  one result per tick: voice_notes, recording_active,
//                playback_active, stored_events, event_dropped
//
// Each tick request is handled in the cycle it is accepted; a new tick can be
// taken every cycle. Its result enters a two-entry output buffer, so ticks keep
// flowing while one result waits; i_in.ready drops only when both entries hold.
// Reset (synchronous, active low) clears all control state; the event store
// has no reset and needs no clearing pass: playback only reads entries written
// since the last record press. The playback loop reads the store through two
// registered-read RAMs, addressed from the next-state position.
module note_event_recorder_player #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ner_in_if.sink    i_in,
    ner_out_if.source o_out
);

    localparam int IW = $clog2(DEPTH);       // store index
    localparam int CW = $clog2(DEPTH + 1);   // entry count 0..DEPTH
    localparam int XW = IW + 2;              // holds position + 2
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]        FULL     = CW'(DEPTH);

    // recording state
    logic [CW-1:0]              r_total,   n_total;
    logic                       r_rec,     n_rec;
    logic [ner_pkg::NOTE_W-1:0] r_last,    n_last;
    logic [TIME_BITS-1:0]       r_ticks,   n_ticks;

    // playback state
    logic                       r_play,    n_play;
    logic [IW-1:0]              r_pos,     n_pos;
    logic [ner_pkg::NOTE_W-1:0] r_ppat,    n_ppat;
    logic [TIME_BITS-1:0]       r_wait,    n_wait;
    logic [TIME_BITS-1:0]       r_elapsed, n_elapsed;

    // copies of entry 0 pattern and entry 1 delta, used by a play press
    logic [ner_pkg::NOTE_W-1:0] r_e0_pat;
    logic [TIME_BITS-1:0]       r_e1_dly;

    // last store write, registered to cover the read-first RAM
    logic                       r_wr_vld;
    logic [IW-1:0]              r_wr_addr;
    logic [ner_pkg::NOTE_W-1:0] r_wr_pat;
    logic [TIME_BITS-1:0]       r_wr_dly;

    logic                       w_tick;
    logic                       w_rdy;
    logic                       w_do_write;
    logic                       w_dropped;
    logic [IW-1:0]              w_wr_addr;
    logic [TIME_BITS-1:0]       w_wr_dly;
    logic [XW-1:0]              w_next1;
    logic [XW-1:0]              w_next2;
    logic [ner_pkg::NOTE_W-1:0] w_pat1;
    logic [TIME_BITS-1:0]       w_dly2;
    logic [ner_pkg::NOTE_W-1:0] w_e0_pat;
    logic [TIME_BITS-1:0]       w_e1_dly;
    logic [TIME_BITS-1:0]       w_el;
    logic [ner_pkg::NOTE_W-1:0] w_ram_pat;
    logic [TIME_BITS-1:0]       w_ram_dly;
    logic [XW-1:0]              w_rd1;
    logic [XW-1:0]              w_rd2;
    ner_pkg::t_result           w_res;

    assign w_tick    = i_in.valid && w_rdy;
    assign i_in.ready = w_rdy;

    always_comb begin
        n_total    = r_total;
        n_rec      = r_rec;
        n_last     = r_last;
        n_ticks    = r_ticks;
        n_play     = r_play;
        n_pos      = r_pos;
        n_ppat     = r_ppat;
        n_wait     = r_wait;
        n_elapsed  = r_elapsed;
        w_do_write = 1'b0;
        w_dropped  = 1'b0;
        w_wr_addr  = r_total[IW-1:0];
        w_wr_dly   = r_ticks;
        w_next1    = XW'(r_pos) + XW'(1);
        w_next2    = XW'(r_pos) + XW'(2);
        w_el       = (r_elapsed == TIME_MAX) ? TIME_MAX : r_elapsed + TIME_BITS'(1);

        if (w_tick) begin
            // record control: a press empties the store and restarts the count
            n_rec = i_in.record_button;
            if (i_in.record_button && !r_rec) begin
                n_total = '0;
                n_last  = '0;
                n_ticks = '0;
            end else if (i_in.record_button) begin
                n_ticks = (r_ticks == TIME_MAX) ? TIME_MAX : r_ticks + TIME_BITS'(1);
            end

            // change detection; a full store drops the entry but keeps timing
            if (i_in.record_button && (i_in.note_bits != n_last)) begin
                if (n_total < FULL) begin
                    w_do_write = 1'b1;
                    w_wr_addr  = n_total[IW-1:0];
                    w_wr_dly   = n_ticks;
                    n_total    = n_total + CW'(1);
                end else begin
                    w_dropped = 1'b1;
                end
                n_ticks = '0;
                n_last  = i_in.note_bits;
            end
        end

        // entry views that include this tick's write and the previous one
        w_e0_pat = (w_do_write && w_wr_addr == '0) ? i_in.note_bits : r_e0_pat;
        w_e1_dly = (w_do_write && w_wr_addr == IW'(1)) ? w_wr_dly : r_e1_dly;
        if (w_do_write && w_wr_addr == w_next1[IW-1:0]) begin
            w_pat1 = i_in.note_bits;
        end else if (r_wr_vld && r_wr_addr == w_next1[IW-1:0]) begin
            w_pat1 = r_wr_pat;
        end else begin
            w_pat1 = w_ram_pat;
        end
        if (w_do_write && w_wr_addr == w_next2[IW-1:0]) begin
            w_dly2 = w_wr_dly;
        end else if (r_wr_vld && r_wr_addr == w_next2[IW-1:0]) begin
            w_dly2 = r_wr_dly;
        end else begin
            w_dly2 = w_ram_dly;
        end

        if (w_tick) begin
            if (i_in.play_button && !r_play && n_total != '0) begin
                // every entry after the first has a delta of at least one, so
                // a press never advances; a single entry stops at once
                n_pos     = '0;
                n_ppat    = w_e0_pat;
                n_elapsed = '0;
                n_play    = (n_total > CW'(1));
                n_wait    = n_play ? w_e1_dly : '0;
            end else if (!i_in.play_button) begin
                n_play = 1'b0;
            end else if (r_play) begin
                n_elapsed = w_el;
                if (w_el >= r_wait) begin
                    if (w_next1 >= XW'(n_total)) begin
                        n_play = 1'b0;
                    end else begin
                        n_pos     = w_next1[IW-1:0];
                        n_ppat    = w_pat1;
                        n_elapsed = '0;
                        n_wait    = (w_next2 < XW'(n_total)) ? w_dly2 : '0;
                    end
                end
            end
        end

        w_res.voice_notes      = n_play ? n_ppat : i_in.note_bits;
        w_res.recording_active = n_rec;
        w_res.playback_active  = n_play;
        w_res.stored_events    = ner_pkg::COUNT_W'(n_total);
        w_res.event_dropped    = w_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_rec     <= 1'b0;
            r_last    <= '0;
            r_ticks   <= '0;
            r_play    <= 1'b0;
            r_pos     <= '0;
            r_ppat    <= '0;
            r_wait    <= '0;
            r_elapsed <= '0;
            r_wr_vld  <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_rec     <= n_rec;
            r_last    <= n_last;
            r_ticks   <= n_ticks;
            r_play    <= n_play;
            r_pos     <= n_pos;
            r_ppat    <= n_ppat;
            r_wait    <= n_wait;
            r_elapsed <= n_elapsed;
            r_wr_vld  <= w_do_write;
        end
    end

    // store-side shadows and write bypass: payload only
    always_ff @(posedge i_clk) begin
        r_wr_addr <= w_wr_addr;
        r_wr_pat  <= i_in.note_bits;
        r_wr_dly  <= w_wr_dly;
        if (w_do_write && w_wr_addr == '0) begin
            r_e0_pat <= i_in.note_bits;
        end
        if (w_do_write && w_wr_addr == IW'(1)) begin
            r_e1_dly <= w_wr_dly;
        end
    end

    // prefetch pattern of position+1 and delta of position+2 for next tick
    assign w_rd1 = XW'(n_pos) + XW'(1);
    assign w_rd2 = XW'(n_pos) + XW'(2);

    ner_ram #(
        .WIDTH (ner_pkg::NOTE_W),
        .DEPTH (DEPTH)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_write),
        .i_waddr (w_wr_addr),
        .i_wdata (i_in.note_bits),
        .i_raddr (w_rd1[IW-1:0]),
        .o_rdata (w_ram_pat)
    );

    ner_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_write),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_dly),
        .i_raddr (w_rd2[IW-1:0]),
        .o_rdata (w_ram_dly)
    );

    ner_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tick),
        .o_ready (w_rdy),
        .i_data  (w_res),
        .o_out   (o_out)
    );

    // playback only starts with at least two entries held
    a_play_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_play) |-> (r_total > CW'(1)))
        else $error("playback started with fewer than two entries");

    // the entry just written is always the last one held
    a_write_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_vld |-> (r_total == CW'(r_wr_addr) + CW'(1)))
        else $error("store write not at the top of the store");

    // ticks are held back only while a result is pending at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("tick channel stalled with no pending result");

endmodule
